FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Operation codes, round constants, initial hash value and sigma functions.
// ----------------------------------------------------------------------------
package shs_pkg;

	typedef enum logic [1:0] {
		OP_ABSORB        = 2'd0,
		OP_ABSORB_FINISH = 2'd1,
		OP_FINISH        = 2'd2
	} op_t;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

FILE: rtl/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Hashes a byte stream with SHA-256 and returns the eight digest words, word 0
// first, with last_word on word 7. The 64th byte of a block starts a
// compression (reading the block memory into the schedule, 64 rounds at one
// round per cycle, adding back into the chaining memory), during which
// item_stall is high. A finish writes up to 16 padding words, one per cycle,
// runs one or two compressions and hands out the digest during the last
// write-back, which waits on dig_stall. Block words and the chaining value
// sit in two single-port-read synchronous memories.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shs_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD  = 6'b000010,
		S_LOAD = 6'b000100,
		S_RND  = 6'b001000,
		S_WBRD = 6'b010000,
		S_WB   = 6'b100000
	} state_t;

	state_t       state_q;
	logic [5:0]   cnt_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [23:0]  acc_q;
	logic         fin_q;
	logic         first_q;
	logic         len_q;
	logic         final_q;
	logic         fresh_q;
	logic [31:0]  sched_q [16];
	logic [31:0]  var_q [8];

	logic [31:0]  blk_mem [16];
	logic [31:0]  blk_rdata_q;
	logic         blk_we;
	logic [3:0]   blk_wa;
	logic [31:0]  blk_wd;

	logic [31:0]  chn_mem [8];
	logic [31:0]  chn_rdata_q;
	logic [2:0]   chn_ra;
	logic [2:0]   chn_ra_q;
	logic [31:0]  chn_word;
	logic         chn_we;

	logic         dig_valid_q;
	logic [31:0]  digest_word_q;
	logic [2:0]   word_index_q;
	logic         last_word_q;

	logic         take;
	logic         absorb;
	logic         finish;
	logic [5:0]   fill_nx;
	logic [31:0]  pad_word;
	logic [31:0]  sched_nx;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  wb_sum;
	logic         slot_free;
	logic         wb_adv;

	assign item_stall  = (state_q != S_IDLE);
	assign take        = item_valid && (state_q == S_IDLE);
	assign absorb      = (op == OP_ABSORB) || (op == OP_ABSORB_FINISH);
	assign finish      = (op == OP_FINISH) || (op == OP_ABSORB_FINISH);
	assign fill_nx     = absorb ? fill_q + 6'd1 : fill_q;
	assign slot_free   = !dig_valid_q || !dig_stall;
	assign wb_adv      = (state_q == S_WB) && (!final_q || slot_free);
	assign chn_word    = fresh_q ? INIT_HASH[chn_ra_q] : chn_rdata_q;
	assign wb_sum      = chn_word + var_q[0];
	assign chn_we      = wb_adv && !final_q;

	always_comb begin
		unique case (fill_q[1:0])
			2'd0: pad_word = {PAD_BYTE, 24'h0};
			2'd1: pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2: pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			2'd3: pad_word = {acc_q, PAD_BYTE};
			default: pad_word = '0;
		endcase
	end

	always_comb begin
		blk_we = 1'b0;
		blk_wa = fill_q[5:2];
		blk_wd = {acc_q, data_byte};
		if (take && absorb && (fill_q[1:0] == 2'd3)) begin
			blk_we = 1'b1;
		end else if (state_q == S_PAD) begin
			blk_we = 1'b1;
			blk_wa = cnt_q[3:0];
			if (first_q) begin
				blk_wd = pad_word;
			end else if (len_q && (cnt_q[3:0] == 4'd14)) begin
				blk_wd = bits_q[63:32];
			end else if (len_q && (cnt_q[3:0] == 4'd15)) begin
				blk_wd = bits_q[31:0];
			end else begin
				blk_wd = '0;
			end
		end
	end

	always_comb begin
		unique case (state_q)
			S_LOAD:  chn_ra = cnt_q[2:0];
			S_WB:    chn_ra = wb_adv ? cnt_q[2:0] + 3'd1 : cnt_q[2:0];
			default: chn_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_wa] <= blk_wd;
		end
		blk_rdata_q <= blk_mem[cnt_q[3:0]];
	end

	always_ff @(posedge clk) begin
		if (chn_we) begin
			chn_mem[cnt_q[2:0]] <= wb_sum;
		end
		chn_rdata_q <= chn_mem[chn_ra];
	end

	// one round of the compression
	always_comb begin
		sched_nx = sched_q[0] + small_sig0(sched_q[1]) + sched_q[9] + small_sig1(sched_q[14]);
		t1 = var_q[7] + big_sig1(var_q[4]) + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
			+ ROUND_K[cnt_q] + sched_q[0];
		t2 = big_sig0(var_q[0])
			+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	always_ff @(posedge clk) begin
		chn_ra_q <= chn_ra;
		unique case (state_q)
			S_LOAD: begin
				if (cnt_q != 6'd0) begin
					for (int i = 0; i < 15; i++) begin
						sched_q[i] <= sched_q[i + 1];
					end
					sched_q[15] <= blk_rdata_q;
				end
				if ((cnt_q != 6'd0) && (cnt_q <= 6'd8)) begin
					for (int i = 0; i < 7; i++) begin
						var_q[i] <= var_q[i + 1];
					end
					var_q[7] <= chn_word;
				end
			end
			S_RND: begin
				for (int i = 0; i < 15; i++) begin
					sched_q[i] <= sched_q[i + 1];
				end
				sched_q[15] <= sched_nx;
				var_q[0] <= t1 + t2;
				var_q[1] <= var_q[0];
				var_q[2] <= var_q[1];
				var_q[3] <= var_q[2];
				var_q[4] <= var_q[3] + t1;
				var_q[5] <= var_q[4];
				var_q[6] <= var_q[5];
				var_q[7] <= var_q[6];
			end
			S_WB: begin
				if (wb_adv) begin
					for (int i = 0; i < 7; i++) begin
						var_q[i] <= var_q[i + 1];
					end
					var_q[7] <= var_q[0];
				end
			end
			default: begin
			end
		endcase
		if (take && absorb) begin
			acc_q <= {acc_q[15:0], data_byte};
		end
		if (wb_adv && final_q) begin
			digest_word_q <= wb_sum;
			word_index_q  <= cnt_q[2:0];
			last_word_q   <= (cnt_q[2:0] == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (wb_adv && final_q) begin
			dig_valid_q <= 1'b1;
		end else if (slot_free) begin
			dig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			final_q <= 1'b0;
			fresh_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						fin_q   <= finish;
						first_q <= 1'b1;
						if (absorb) begin
							fill_q <= fill_nx;
							bits_q <= bits_q + 64'd8;
						end
						if (absorb && (fill_q == 6'd63)) begin
							state_q <= S_LOAD;
							cnt_q   <= '0;
							final_q <= 1'b0;
						end else if (finish) begin
							state_q <= S_PAD;
							cnt_q   <= {2'b00, fill_nx[5:2]};
							len_q   <= (fill_nx < LEN_START);
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (cnt_q[3:0] == 4'd15) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
						final_q <= len_q;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_LOAD: begin
					if (cnt_q == 6'd16) begin
						state_q <= S_RND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_RND: begin
					if (cnt_q == 6'd63) begin
						state_q <= S_WBRD;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_WBRD: begin
					state_q <= S_WB;
					cnt_q   <= '0;
				end
				S_WB: begin
					if (wb_adv) begin
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q[2:0] == 3'd7) begin
							fill_q <= '0;
							if (final_q) begin
								fresh_q <= 1'b1;
								bits_q  <= '0;
								fin_q   <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								fresh_q <= 1'b0;
								if (fin_q) begin
									state_q <= S_PAD;
									cnt_q   <= '0;
									len_q   <= 1'b1;
								end else begin
									state_q <= S_IDLE;
								end
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign dig_valid   = dig_valid_q;
	assign digest_word = digest_word_q;
	assign word_index  = word_index_q;
	assign last_word   = last_word_q;

	`ASSERT_NEXT(a_dig_from_final_wb, clk, arst_n, !dig_valid_q, !dig_valid_q || ($past(state_q == S_WB) && $past(final_q)))
	`ASSERT_NEXT(a_word_order, clk, arst_n, dig_valid_q && !dig_stall && !last_word_q, !dig_valid_q || (word_index_q == $past(word_index_q) + 3'd1))
	`ASSERT_IMPLIES(a_final_needs_finish, clk, arst_n, (state_q == S_LOAD) && final_q, fin_q)
	`ASSERT_IMPLIES(a_pad_in_block, clk, arst_n, state_q == S_PAD, cnt_q[5:4] == 2'b00)

endmodule
